// ----- rtl/mrrp_pkg.sv -----
// package for the meter result record parser
// types and constants used by the rtl; no dependencies
package mrrp_pkg;

  localparam logic [7:0] SepReset = 8'd124;

  localparam logic [3:0] PhStart   = 4'd0;
  localparam logic [3:0] PhIndex   = 4'd1;
  localparam logic [3:0] PhType    = 4'd2;
  localparam logic [3:0] PhValue   = 4'd3;
  localparam logic [3:0] PhUnits   = 4'd4;
  localparam logic [3:0] PhSkip1   = 4'd5;
  localparam logic [3:0] PhTags    = 4'd6;
  localparam logic [3:0] PhTagHex  = 4'd7;
  localparam logic [3:0] PhSkipTag = 4'd8;
  localparam logic [3:0] PhSkip2   = 4'd9;
  localparam logic [3:0] PhDate    = 4'd10;
  localparam logic [3:0] PhDone    = 4'd11;

  localparam logic [2:0] TypeGlucose = 3'd0;
  localparam logic [2:0] TypeShort   = 3'd1;
  localparam logic [2:0] TypeLong    = 3'd2;
  localparam logic [2:0] TypeCarb    = 3'd3;
  localparam logic [2:0] TypeUnknown = 3'd4;

  // glucose tag letter bits
  localparam logic [7:0] TagC = 8'd1;
  localparam logic [7:0] TagB = 8'd2;
  localparam logic [7:0] TagA = 8'd4;
  localparam logic [7:0] TagD = 8'd8;
  localparam logic [7:0] TagI = 8'd16;
  localparam logic [7:0] TagS = 8'd32;
  localparam logic [7:0] TagX = 8'd64;

  localparam logic [7:0] TagNonGlucose = 8'd128;
  localparam logic [15:0] ValueLow  = 16'd9;
  localparam logic [15:0] ValueHigh = 16'd601;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_record;
  } in_word_t;

  typedef struct packed {
    logic        parse_ok;
    logic [15:0] record_index;
    logic [2:0]  type_code;
    logic [15:0] measured_value;
    logic [7:0]  tag_bits;
    logic [7:0]  extra_tag;
    logic [13:0] year;
    logic [4:0]  month;
    logic [5:0]  day;
    logic [4:0]  hour;
    logic [6:0]  minute;
  } out_word_t;

  // lower-case ascii letters
  function automatic logic [7:0] fold(input logic [7:0] c);
    fold = (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
  endfunction

  function automatic logic [7:0] name_glucose(input logic [3:0] p);
    unique case (p)
      4'd0, 4'd1, 4'd2: name_glucose = 8'h5e;
      4'd3: name_glucose = 8'h67;
      4'd4: name_glucose = 8'h6c;
      4'd5: name_glucose = 8'h75;
      4'd6: name_glucose = 8'h63;
      4'd7: name_glucose = 8'h6f;
      4'd8: name_glucose = 8'h73;
      4'd9: name_glucose = 8'h65;
      default: name_glucose = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] name_insulin(input logic [3:0] p);
    unique case (p)
      4'd0, 4'd1, 4'd2: name_insulin = 8'h5e;
      4'd3: name_insulin = 8'h69;
      4'd4: name_insulin = 8'h6e;
      4'd5: name_insulin = 8'h73;
      4'd6: name_insulin = 8'h75;
      4'd7: name_insulin = 8'h6c;
      4'd8: name_insulin = 8'h69;
      4'd9: name_insulin = 8'h6e;
      default: name_insulin = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] name_carb(input logic [3:0] p);
    unique case (p)
      4'd0, 4'd1, 4'd2: name_carb = 8'h5e;
      4'd3: name_carb = 8'h63;
      4'd4: name_carb = 8'h61;
      4'd5: name_carb = 8'h72;
      4'd6: name_carb = 8'h62;
      default: name_carb = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] name_long(input logic [3:0] p);
    unique case (p)
      4'd0: name_long = 8'h32;
      4'd1: name_long = 8'h5e;
      default: name_long = 8'h00;
    endcase
  endfunction

  // acc * 10 + digit, saturating
  function automatic logic [15:0] add_digit(input logic [15:0] acc, input logic [7:0] c);
    logic [19:0] v;
    v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {16'd0, c[3:0]};
    add_digit = (v > 20'd65535) ? 16'hffff : v[15:0];
  endfunction

endpackage

// ----- rtl/mrrp_if.sv -----
// valid/ready channel carrying one word of type word_t
// no dependencies; the word type is a parameter
interface mrrp_if #(parameter type word_t = logic [7:0]) ();
  logic  valid;
  logic  ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/meter_result_record_parser_top.sv -----
// meter result record parser, top level
// depends on mrrp_pkg and mrrp_if
//
//  channel  | dir | word
//  in_if    | in  | data_byte, end_of_record
//  out_if   | out | parse result, one per record
//  cfg_if   | in  | field separator byte
//
// one byte per cycle: a byte is parsed in the cycle it is accepted, against
// the registered parse state; the result lands in an output register.
// input ready drops only while a result is held and the sink stalls.
// reset restores separator '|' and clears the parse state.
module meter_result_record_parser_top (
  input logic clk_i,
  input logic rst_ni,
  mrrp_if.sink   in_if,
  mrrp_if.source out_if,
  mrrp_if.sink   cfg_if
);

  logic [7:0]  sep_q;
  logic [3:0]  phase_q, phase_d;
  logic        err_q, err_d;
  logic [15:0] idx_q, idx_d, val_q, val_d;
  logic [3:0]  flags_q, flags_d;
  logic [3:0]  pos_q, pos_d;
  logic [2:0]  type_q, type_d;
  logic [7:0]  tag_q, tag_d, xtag_q, xtag_d;
  logic [3:0]  stamp_q [12];
  logic [3:0]  cnt_q, cnt_d;
  logic        out_valid_q;
  mrrp_pkg::out_word_t out_q, res;

  logic [7:0] c, f, lim;
  logic       take, is_sep, is_dig;

  assign in_if.ready  = !out_valid_q || out_if.ready;
  assign take         = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;
  assign c      = in_if.data.data_byte;
  assign f      = mrrp_pkg::fold(c);
  assign is_sep = (c == sep_q);
  assign is_dig = (c >= 8'h30 && c <= 8'h39);

  // digit limit for the date tens positions
  always_comb begin
    unique case (cnt_q)
      4'd4:    lim = 8'h31;
      4'd6:    lim = 8'h33;
      4'd8:    lim = 8'h32;
      4'd10:   lim = 8'h36;
      default: lim = 8'h39;
    endcase
  end

  // per-byte parse step
  always_comb begin
    phase_d = phase_q; err_d = err_q; idx_d = idx_q; val_d = val_q;
    flags_d = flags_q; pos_d = pos_q; type_d = type_q; tag_d = tag_q;
    xtag_d = xtag_q; cnt_d = cnt_q;
    if (!err_q) begin
      unique case (phase_q)
        mrrp_pkg::PhStart: begin
          if (is_sep) phase_d = mrrp_pkg::PhIndex; else err_d = 1'b1;
        end
        mrrp_pkg::PhIndex: begin
          if (is_sep) begin
            phase_d = mrrp_pkg::PhType; pos_d = 4'd0; flags_d = 4'hf;
          end else if (is_dig) idx_d = mrrp_pkg::add_digit(idx_q, c);
          else err_d = 1'b1;
        end
        mrrp_pkg::PhType: begin
          if (is_sep) begin
            if (flags_q[0] && pos_q == 4'd10) type_d = mrrp_pkg::TypeGlucose;
            else if (flags_q[1] && pos_q == 4'd10) type_d = mrrp_pkg::TypeShort;
            else if (flags_q[2] && pos_q == 4'd7) type_d = mrrp_pkg::TypeCarb;
            else type_d = mrrp_pkg::TypeUnknown;
            phase_d = mrrp_pkg::PhValue;
          end else begin
            if (pos_q >= 4'd10 || mrrp_pkg::name_glucose(pos_q) != f) flags_d[0] = 1'b0;
            if (pos_q >= 4'd10 || mrrp_pkg::name_insulin(pos_q) != f) flags_d[1] = 1'b0;
            if (pos_q >= 4'd7 || mrrp_pkg::name_carb(pos_q) != f) flags_d[2] = 1'b0;
            if (pos_q != 4'd15) pos_d = pos_q + 4'd1;
          end
        end
        mrrp_pkg::PhValue: begin
          if (is_sep) begin
            phase_d = mrrp_pkg::PhUnits; pos_d = 4'd0;
          end else if (is_dig) val_d = mrrp_pkg::add_digit(val_q, c);
          else err_d = 1'b1;
        end
        mrrp_pkg::PhUnits: begin
          if (is_sep) begin
            if (type_q == mrrp_pkg::TypeShort && flags_q[3] && pos_q == 4'd2)
              type_d = mrrp_pkg::TypeLong;
            phase_d = mrrp_pkg::PhSkip1;
          end else begin
            if (pos_q >= 4'd2 || mrrp_pkg::name_long(pos_q) != f) flags_d[3] = 1'b0;
            if (pos_q != 4'd15) pos_d = pos_q + 4'd1;
          end
        end
        mrrp_pkg::PhSkip1: begin
          if (is_sep) begin
            if (type_q == mrrp_pkg::TypeGlucose) phase_d = mrrp_pkg::PhTags;
            else begin
              tag_d = mrrp_pkg::TagNonGlucose;
              xtag_d = {5'd0, type_q - 3'd1};
              phase_d = mrrp_pkg::PhSkipTag;
            end
          end
        end
        mrrp_pkg::PhTags: begin
          if (is_sep) phase_d = mrrp_pkg::PhSkip2;
          else begin
            unique case (c)
              8'h43: tag_d = tag_q | mrrp_pkg::TagC;
              8'h42: tag_d = tag_q | mrrp_pkg::TagB;
              8'h41: tag_d = tag_q | mrrp_pkg::TagA;
              8'h44: tag_d = tag_q | mrrp_pkg::TagD;
              8'h49: tag_d = tag_q | mrrp_pkg::TagI;
              8'h53: tag_d = tag_q | mrrp_pkg::TagS;
              8'h58: tag_d = tag_q | mrrp_pkg::TagX;
              8'h3c: val_d = mrrp_pkg::ValueLow;
              8'h3e: val_d = mrrp_pkg::ValueHigh;
              8'h5a: begin tag_d = tag_q | mrrp_pkg::TagA; phase_d = mrrp_pkg::PhTagHex; end
              default: ;
            endcase
          end
        end
        mrrp_pkg::PhTagHex: begin
          // 15 * n = 16n - n
          if (is_dig) begin
            xtag_d = {c[3:0], 4'd0} - {4'd0, c[3:0]};
            phase_d = mrrp_pkg::PhTags;
          end else if (f >= 8'h61 && f <= 8'h66) begin
            xtag_d = {f[3:0] + 4'd9, 4'd0} - {4'd0, f[3:0] + 4'd9};
            phase_d = mrrp_pkg::PhTags;
          end else err_d = 1'b1;
        end
        mrrp_pkg::PhSkipTag: if (is_sep) phase_d = mrrp_pkg::PhSkip2;
        mrrp_pkg::PhSkip2: begin
          if (is_sep) begin phase_d = mrrp_pkg::PhDate; cnt_d = 4'd0; end
        end
        mrrp_pkg::PhDate: begin
          if (c < 8'h30 || c > lim || cnt_q >= 4'd12) err_d = 1'b1;
          else begin
            cnt_d = cnt_q + 4'd1;
            if (cnt_q == 4'd11) phase_d = mrrp_pkg::PhDone;
          end
        end
        mrrp_pkg::PhDone: ;
        default: err_d = 1'b1;
      endcase
    end
  end

  // result assembly from next-state values; stamp digits via date write path
  logic [3:0] dg [12];
  always_comb begin
    for (int i = 0; i < 12; i++) begin
      dg[i] = (phase_q == mrrp_pkg::PhDate && !err_d && cnt_q == 4'(i))
              ? c[3:0] : stamp_q[i];
    end
    res = '0;
    if (!err_d && phase_d == mrrp_pkg::PhDone) begin
      res.parse_ok       = 1'b1;
      res.record_index   = idx_d;
      res.type_code      = type_d;
      res.measured_value = val_d;
      res.tag_bits       = tag_d;
      res.extra_tag      = xtag_d;
      res.year   = 14'(dg[0]) * 14'd1000 + 14'(dg[1]) * 14'd100
                 + 14'(dg[2]) * 14'd10 + 14'(dg[3]);
      res.month  = 5'(dg[4]) * 5'd10 + 5'(dg[5]);
      res.day    = 6'(dg[6]) * 6'd10 + 6'(dg[7]);
      res.hour   = 5'(dg[8]) * 5'd10 + 5'(dg[9]);
      res.minute = 7'(dg[10]) * 7'd10 + 7'(dg[11]);
    end
  end

  // timestamp digit store
  always_ff @(posedge clk_i) begin
    if (take && phase_q == mrrp_pkg::PhDate && !err_d && !err_q)
      stamp_q[cnt_q] <= c[3:0];
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (take && in_if.data.end_of_record) out_q <= res;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q <= mrrp_pkg::SepReset;
      phase_q <= mrrp_pkg::PhStart; err_q <= 1'b0; idx_q <= '0; val_q <= '0;
      flags_q <= 4'hf; pos_q <= '0; type_q <= '0; tag_q <= '0; xtag_q <= '0;
      cnt_q <= '0; out_valid_q <= 1'b0;
    end else begin
      if (cfg_if.valid) sep_q <= cfg_if.data;
      // result held until the sink takes it; a new last byte reloads it
      out_valid_q <= (take && in_if.data.end_of_record) || (out_valid_q && !out_if.ready);
      if (take) begin
        if (in_if.data.end_of_record) begin
          phase_q <= mrrp_pkg::PhStart; err_q <= 1'b0; idx_q <= '0; val_q <= '0;
          flags_q <= 4'hf; pos_q <= '0; type_q <= '0; tag_q <= '0; xtag_q <= '0;
          cnt_q <= '0;
        end else begin
          phase_q <= phase_d; err_q <= err_d; idx_q <= idx_d; val_q <= val_d;
          flags_q <= flags_d; pos_q <= pos_d; type_q <= type_d; tag_q <= tag_d;
          xtag_q <= xtag_d; cnt_q <= cnt_d;
        end
      end
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_q;

endmodule
